>>> sv/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII unit.
package sbda_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // BCD digit handling
    localparam int         DIGIT_BITS    = 4;
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;
    localparam logic [3:0] DIGIT_MAX     = 4'd9;

    // Output item layout
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int OUT_TDATA_W = 16;

    // Source of the next output character
    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_DIGIT,
        SEL_TERM
    } char_sel_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SIGN  = 5'b00100,
        ST_DIGIT = 5'b01000,
        ST_TERM  = 5'b10000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      step;
        logic      set_top;
        logic      out_load;
        logic      out_last;
        char_sel_t char_sel;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;
        logic digit_last;
        logic negative;
        logic terminator;
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/sbda_dp.sv
// Datapath: magnitude, double-dabble BCD register, digit pointer and output register.
module sbda_dp
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   add_terminator,
    output logic [CHAR_W-1:0]      character,
    output logic                   last,
    output logic [COUNT_W-1:0]     char_count,
    output logic                   out_valid,
    input  logic                   out_ready
);

    // Digits needed for the widest magnitude, and how many of them are kept
    localparam int NUM_BCD = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int KEEP    = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
    localparam int IDX_W   = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [DIGIT_BITS-1:0]  bcd_reg [NUM_BCD];
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]       idx_reg;
    logic                   neg_reg;
    logic                   term_reg;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    logic [VALUE_WIDTH-1:0] neg_value;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [DIGIT_BITS-1:0]  adj     [NUM_BCD];
    logic [DIGIT_BITS-1:0]  shifted [NUM_BCD];
    logic [IDX_W-1:0]       top_idx;
    logic [DIGIT_BITS-1:0]  cur_digit;
    logic [CHAR_W-1:0]      char_mux;
    logic                   out_free;

    // Take the true magnitude; the most negative value wraps to its own magnitude
    assign neg_value = ~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    assign mag_in    = value[VALUE_WIDTH-1] ? neg_value : value;

    // One double-dabble step: add 3 to digits of 5 or more, then shift in one bit
    always_comb
    begin
        for (int i = 0; i < NUM_BCD; i++)
        begin
            adj[i] = (bcd_reg[i] >= BCD_ADJ_LIMIT) ? bcd_reg[i] + BCD_ADJ : bcd_reg[i];
        end
        shifted[0] = {adj[0][DIGIT_BITS-2:0], mag_reg[VALUE_WIDTH-1]};
        for (int i = 1; i < NUM_BCD; i++)
        begin
            shifted[i] = {adj[i][DIGIT_BITS-2:0], adj[i-1][DIGIT_BITS-1]};
        end
    end

    // Find the most significant nonzero kept digit; zero gives digit 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < KEEP; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg];
    assign out_free  = !out_valid_reg || out_ready;

    // Select the character to send
    always_comb
    begin
        unique case (cmd.char_sel)
            SEL_SIGN:  char_mux = CHAR_MINUS;
            SEL_DIGIT: char_mux = CHAR_ZERO + {{(CHAR_W-DIGIT_BITS){1'b0}}, cur_digit};
            SEL_TERM:  char_mux = CHAR_NUL;
            default:   char_mux = CHAR_NUL;
        endcase
    end

    // Next values of the control registers
    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        if (cmd.load)
        begin
            bit_cnt_next = CNT_W'(VALUE_WIDTH);
        end
        else if (cmd.step)
        begin
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = '0;
        end
        else if (cmd.out_load)
        begin
            count_next = count_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the conversion and load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= mag_in;
            neg_reg  <= value[VALUE_WIDTH-1];
            term_reg <= add_terminator;
            for (int i = 0; i < NUM_BCD; i++)
            begin
                bcd_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            mag_reg <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            for (int i = 0; i < NUM_BCD; i++)
            begin
                bcd_reg[i] <= shifted[i];
            end
        end

        if (cmd.set_top)
        begin
            idx_reg <= top_idx;
        end
        else if (cmd.out_load && cmd.char_sel == SEL_DIGIT)
        begin
            idx_reg <= idx_reg - 1'b1;
        end

        if (cmd.out_load)
        begin
            char_reg      <= char_mux;
            last_reg      <= cmd.out_last;
            out_count_reg <= cmd.out_last ? count_reg + 1'b1 : '0;
        end
    end

    assign status.conv_done  = (bit_cnt_reg == '0);
    assign status.digit_last = (idx_reg == '0);
    assign status.negative   = neg_reg;
    assign status.terminator = term_reg;
    assign status.out_free   = out_free;

    assign character  = char_reg;
    assign last       = last_reg;
    assign char_count = out_count_reg;
    assign out_valid  = out_valid_reg;

    // Every digit sent is a decimal digit
    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.char_sel == SEL_DIGIT |-> cur_digit <= DIGIT_MAX)
        else $error("non-decimal digit sent");

endmodule

>>> sv/sbda_ctrl.sv
// Controller: sequences load, conversion steps and character emission.
module sbda_ctrl
    import sbda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Decode next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.char_sel = SEL_DIGIT;
        in_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!status.conv_done)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.set_top = 1'b1;
                    state_next  = status.negative ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                cmd.char_sel = SEL_SIGN;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.char_sel = SEL_DIGIT;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = status.digit_last && !status.terminator;
                    if (status.digit_last)
                    begin
                        state_next = status.terminator ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                cmd.char_sel = SEL_TERM;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    a_no_step_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !status.conv_done)
        else $error("conversion step past the last bit");

    a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_CONV)
        else $error("accepted item did not start conversion");

endmodule

>>> sv/signed_binary_to_decimal_ascii_unit.sv
// Top level of the signed binary to decimal ASCII unit.
//
//  channel   direction  tdata                                  tuser           tlast
//  s_axis    in         value [VALUE_WIDTH-1:0], zero pad      add_terminator  -
//  m_axis    out        character [7:0], char_count [11:8]     -               last char
//
// Sequence: the item is accepted, VALUE_WIDTH shift-add-3 steps run in the BCD register (set by
// the bit counter), the leading digit is found, then one character per cycle is sent while
// the output is free, up to 12 characters by default.
// Reset clears the controller, bit counter, character count and output valid.
// The output register lets the last character wait while the next item is accepted.
// A stalled output holds the emitter in its state; no character is dropped.
module signed_binary_to_decimal_ascii_unit
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // value
    input  logic                                  s_axis_tuser,  // add_terminator
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,  // character, char_count
    output logic                                  m_axis_tlast
);

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [CHAR_W-1:0]  character;
    logic [COUNT_W-1:0] char_count;

    sbda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .value          (s_axis_tdata[VALUE_WIDTH-1:0]),
        .add_terminator (s_axis_tuser),
        .character      (character),
        .last           (m_axis_tlast),
        .char_count     (char_count),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready)
    );

    // Pack the output item
    assign m_axis_tdata = {{(OUT_TDATA_W-CHAR_W-COUNT_W){1'b0}}, char_count, character};

    a_count_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> char_count == '0)
        else $error("character count on a non-final character");

endmodule

>>> tb/signed_binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for the signed binary to decimal ASCII unit.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit_tb;
    import sbda_pkg::*;

    localparam int VALUE_W = 32;
    localparam int IN_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int MAX_CHARS = 12;

    // Handshake pacing phases
    typedef enum int {
        PH_FREE,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } pace_t;

    // One number waiting to be sent
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               terminate;
        pace_t              pace;
        bit                 drain_first;
    } number_item_t;

    // One character the block should emit
    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } ascii_char_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     m_axis_tlast;

    number_item_t number_queue[$];
    ascii_char_t  expected_chars[$];
    pace_t        cur_pace = PH_FREE;
    int unsigned  chars_predicted = 0;
    int unsigned  chars_checked = 0;
    int unsigned  numbers_sent = 0;
    int unsigned  negatives_sent = 0;
    int unsigned  terminated_sent = 0;
    int unsigned  fail_count = 0;

    signed_binary_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_W),
        .MAX_DIGITS (10)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Record a failure, print only the first few
    task automatic flag_failure(input string what);
        if (fail_count < 10)
            $display("ERROR @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Queue the characters one number turns into; return how many
    function automatic int predict_ascii(input logic [VALUE_W-1:0] value,
                                         input logic terminate);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[MAX_CHARS];
        logic [CHAR_W-1:0]  chars[MAX_CHARS];
        int                 nd;
        int                 nc;
        ascii_char_t        c;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        nd = 0;
        nc = 0;
        // Collect digits least significant first; the most negative value
        // negates to its own true magnitude as an unsigned vector
        do begin
            digits[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            chars[nc] = CHAR_MINUS;
            nc++;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            chars[nc] = CHAR_ZERO + digits[i];
            nc++;
        end
        if (terminate) begin
            chars[nc] = CHAR_NUL;
            nc++;
        end
        for (int i = 0; i < nc; i++) begin
            c.ch = chars[i];
            c.last = (i == nc - 1);
            c.count = c.last ? nc[COUNT_W-1:0] : '0;
            expected_chars.push_back(c);
        end
        return nc;
    endfunction

    function automatic int src_idle_pct(input pace_t p);
        return (p == PH_SRC_GAPS) ? 48 : (p == PH_BOTH) ? 12 : 0;
    endfunction

    function automatic int sink_stall_pct(input pace_t p);
        return (p == PH_SINK_STALLS) ? 48 : (p == PH_BOTH) ? 12 : 0;
    endfunction

    task automatic add_number(input logic [VALUE_W-1:0] value, input logic terminate,
                              input pace_t pace, input bit drain_first);
        number_item_t it;
        it.value = value;
        it.terminate = terminate;
        it.pace = pace;
        it.drain_first = drain_first;
        number_queue.push_back(it);
    endtask

    // Pick a value with a spread of digit counts, signs and boundaries
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        longint unsigned    p10;
        int                 k;
        p10 = 1;
        k = $urandom_range(1, 9);
        repeat (k) p10 = p10 * 10;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = VALUE_W'($urandom % p10);
            3: v = VALUE_W'(p10 - $urandom_range(0, 1));
            4: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(1))
            v = ~v + 1'b1;
        return v;
    endfunction

    // Driver: present numbers from the queue, hold until accepted
    always @(posedge clk) begin : driver
        number_item_t nxt;
        bit           show;
        int unsigned  predicted_now;
        show = 1'b0;
        predicted_now = chars_predicted;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            // Retire the accepted number into the expected characters
            if (s_axis_tvalid) begin
                predicted_now += predict_ascii(s_axis_tdata[VALUE_W-1:0], s_axis_tuser);
                numbers_sent <= numbers_sent + 1;
                negatives_sent <= negatives_sent + s_axis_tdata[VALUE_W-1];
                terminated_sent <= terminated_sent + s_axis_tuser;
                void'(number_queue.pop_front());
            end
            chars_predicted <= predicted_now;
            if (number_queue.size() > 0) begin
                nxt = number_queue[0];
                if (nxt.drain_first && predicted_now != chars_checked)
                    show = 1'b0;
                else
                    show = ($urandom_range(99) >= src_idle_pct(nxt.pace));
            end
            s_axis_tvalid <= show;
            if (show) begin
                s_axis_tdata <= nxt.value;
                s_axis_tuser <= nxt.terminate;
                cur_pace <= nxt.pace;
            end
        end
    end

    // Monitor: compare each accepted character with the oldest expectation
    always @(posedge clk) begin : monitor
        ascii_char_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    flag_failure($sformatf("unexpected item tdata=%h tlast=%b",
                                           m_axis_tdata, m_axis_tlast));
                end
                else begin
                    want = expected_chars.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (m_axis_tdata !== {{(OUT_TDATA_W - CHAR_W - COUNT_W){1'b0}},
                                          want.count, want.ch}
                        || m_axis_tlast !== want.last)
                        flag_failure($sformatf(
                            "char exp %h cnt exp %0d last exp %b, got tdata=%h tlast=%b",
                            want.ch, want.count, want.last, m_axis_tdata, m_axis_tlast));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct(cur_pace));
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        pace_t ph;
        // Directed: extremes, zero, digit-count boundaries, 16-bit unsigned range
        add_number(32'd0, 1'b0, PH_FREE, 1'b0);
        add_number(32'd0, 1'b1, PH_FREE, 1'b0);
        add_number(32'd1, 1'b0, PH_FREE, 1'b0);
        add_number(-32'sd1, 1'b1, PH_FREE, 1'b0);
        add_number(32'd9, 1'b0, PH_FREE, 1'b0);
        add_number(32'd10, 1'b1, PH_FREE, 1'b0);
        add_number(-32'sd10, 1'b0, PH_FREE, 1'b0);
        add_number(32'd99, 1'b0, PH_FREE, 1'b0);
        add_number(-32'sd100, 1'b1, PH_FREE, 1'b0);
        add_number(32'h7FFF_FFFF, 1'b0, PH_FREE, 1'b0);
        add_number(32'h7FFF_FFFF, 1'b1, PH_FREE, 1'b0);
        add_number(32'h8000_0000, 1'b0, PH_FREE, 1'b1);
        add_number(32'h8000_0000, 1'b1, PH_FREE, 1'b0);
        add_number(32'h8000_0001, 1'b1, PH_FREE, 1'b0);
        add_number(32'd1000000000, 1'b0, PH_FREE, 1'b0);
        add_number(32'd999999999, 1'b1, PH_FREE, 1'b0);
        add_number(-32'sd999999999, 1'b0, PH_FREE, 1'b0);
        add_number(32'd65535, 1'b0, PH_FREE, 1'b0);
        add_number(32'd32768, 1'b1, PH_FREE, 1'b0);
        add_number(32'd1234567890, 1'b1, PH_FREE, 1'b0);
        add_number(-32'sd1234567890, 1'b1, PH_FREE, 1'b0);
        add_number(32'h5555_5555, 1'b0, PH_FREE, 1'b0);
        add_number(32'hAAAA_AAAA, 1'b1, PH_FREE, 1'b0);
        // Random numbers, one block per pacing phase, draining at each switch
        for (int p = 0; p < 4; p++) begin
            ph = pace_t'(p);
            for (int i = 0; i < 52; i++)
                add_number(random_value(), $urandom_range(1), ph, (i == 0));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all numbers to go in and all characters to come out
        while (number_queue.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (chars_checked != chars_predicted)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (expected_chars.size() != 0)
            flag_failure($sformatf("%0d characters never arrived", expected_chars.size()));
        $display("Converted %0d numbers (%0d negative, %0d with NUL) into %0d characters,",
                 numbers_sent, negatives_sent, terminated_sent, chars_checked);
        $display("with free-running, source-gap, sink-stall and mixed pacing; %0d errors.",
                 fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
